>>> sv/crc7_framed_command_receiver_defines.svh
// ----------------------------------------------------------------------------
// CRC7 framed command receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef CRC7_FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define CRC7_FRAMED_COMMAND_RECEIVER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define CRC7FCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define CRC7FCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/crc7fcr_pkg.sv
// ----------------------------------------------------------------------------
// CRC7 framed command receiver package
// Request and result types, framing constants and the check-value step.
// ----------------------------------------------------------------------------
package crc7fcr_pkg;

    // Request kinds
    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Result causes
    typedef enum logic
    {
        CAUSE_PACKET  = 1'b0,
        CAUSE_TIMEOUT = 1'b1
    } cause_t;

    typedef struct packed
    {
        op_t        operation;
        logic [7:0] rx_byte;
    } cmd_item_t;

    typedef struct packed
    {
        logic [7:0] port_direction;
        logic       button_level;
        cause_t     cause;
    } res_item_t;

    localparam logic [7:0]  CHECK_POLY    = 8'h89;
    localparam logic [7:0]  START_BYTE    = 8'h80;
    localparam logic [6:0]  DATA_MASK     = 7'h7F;
    localparam logic [13:0] ERR_HIGH_BIT  = 14'h2000;
    localparam logic [13:0] ERR_HIGH_KEEP = 14'h01F0;
    localparam logic [13:0] ERR_LOW_BIT   = 14'h1000;
    localparam logic [13:0] ERR_LOW_KEEP  = 14'h000F;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Merge data by OR, then run eight shift steps of the check polynomial
    function automatic logic [7:0] check_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] t;
        t = acc | data;
        for (int i = 0; i < 8; i++)
        begin
            if (t[7])
            begin
                t = t ^ CHECK_POLY;
            end
            t = {t[6:0], 1'b0};
        end
        return t;
    endfunction

endpackage

>>> sv/crc7fcr_frame.sv
// ----------------------------------------------------------------------------
// CRC7 framed command receiver framing core
// Holds framing, check and timeout state and computes one request's result.
// ----------------------------------------------------------------------------
`include "crc7_framed_command_receiver_defines.svh"

module crc7fcr_frame
    import crc7fcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  cmd_item_t   item,
    input  logic [15:0] timeout_ticks,
    output logic        hit,
    output res_item_t   result
);

    localparam logic [1:0] IDX_HIGH  = 2'd0;
    localparam logic [1:0] IDX_LOW   = 2'd1;
    localparam logic [1:0] IDX_CHECK = 2'd2;
    localparam logic [1:0] IDX_DONE  = 2'd3;

    logic        in_packet_reg, in_packet_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [13:0] word_accum_reg, word_accum_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] timeout_count_reg, timeout_count_next;

    logic        is_start;
    logic        is_data;
    logic        packet_ok;
    logic [7:0]  crc_step;
    logic [15:0] count_dec;
    logic [13:0] word_masked;

    // Step the check value; a start byte seeds from zero
    assign is_start = (item.rx_byte == START_BYTE);
    assign crc_step = check_step(is_start ? 8'h00 : crc_reg, item.rx_byte);
    assign is_data  = in_packet_reg && !item.rx_byte[7] && (byte_index_reg != IDX_DONE);

    // Saturating tick countdown
    assign count_dec = (timeout_count_reg != 16'd0) ? (timeout_count_reg - 16'd1) : 16'd0;

    // Apply error masks to the assembled word
    always_comb
    begin
        word_masked = word_accum_reg;
        if ((word_masked & ERR_HIGH_BIT) != 14'd0)
        begin
            word_masked = word_masked & ERR_HIGH_KEEP;
        end
        if ((word_masked & ERR_LOW_BIT) != 14'd0)
        begin
            word_masked = word_masked & ERR_LOW_KEEP;
        end
    end

    assign packet_ok = (item.operation == OP_BYTE) && !is_start && is_data &&
                       (byte_index_reg == IDX_CHECK) && ({1'b0, crc_reg[7:1]} == item.rx_byte);

    // Next state and result
    always_comb
    begin
        in_packet_next     = in_packet_reg;
        byte_index_next    = byte_index_reg;
        word_accum_next    = word_accum_reg;
        crc_next           = crc_reg;
        timeout_count_next = timeout_count_reg;
        hit                = 1'b0;
        result.port_direction = ~word_masked[8:1];
        result.button_level   = word_masked[0];
        result.cause          = CAUSE_PACKET;

        case (item.operation)
            OP_TICK:
            begin
                timeout_count_next = count_dec;
                if (count_dec == 16'd0)
                begin
                    hit                   = 1'b1;
                    result.port_direction = 8'hFF;
                    result.button_level   = 1'b0;
                    result.cause          = CAUSE_TIMEOUT;
                end
            end
            OP_BYTE:
            begin
                if (is_start)
                begin
                    in_packet_next  = 1'b1;
                    byte_index_next = IDX_HIGH;
                    word_accum_next = 14'd0;
                    crc_next        = crc_step;
                end
                else if (is_data)
                begin
                    case (byte_index_reg)
                        IDX_HIGH:
                        begin
                            word_accum_next = {item.rx_byte[6:0], 7'd0};
                            crc_next        = crc_step;
                            byte_index_next = IDX_LOW;
                        end
                        IDX_LOW:
                        begin
                            word_accum_next = word_accum_reg | {7'd0, item.rx_byte[6:0] & DATA_MASK};
                            crc_next        = crc_step;
                            byte_index_next = IDX_CHECK;
                        end
                        default:
                        begin
                            // Check byte closes the packet either way
                            byte_index_next = IDX_DONE;
                            in_packet_next  = 1'b0;
                            if (packet_ok)
                            begin
                                hit                = 1'b1;
                                timeout_count_next = timeout_ticks;
                            end
                        end
                    endcase
                end
                else
                begin
                    // Drop the packet on a stray control byte or idle byte
                    in_packet_next = 1'b0;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    // Advance state once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg     <= 1'b0;
            byte_index_reg    <= IDX_HIGH;
            word_accum_reg    <= 14'd0;
            crc_reg           <= 8'd0;
            timeout_count_reg <= TIMEOUT_RESET;
        end
        else if (step_en)
        begin
            in_packet_reg     <= in_packet_next;
            byte_index_reg    <= byte_index_next;
            word_accum_reg    <= word_accum_next;
            crc_reg           <= crc_next;
            timeout_count_reg <= timeout_count_next;
        end
    end

    `CRC7FCR_ASSERT_NOW(a_open_packet_index, in_packet_reg, byte_index_reg != IDX_DONE,
        "open packet with spent byte index")
    `CRC7FCR_ASSERT_NOW(a_timeout_pattern, hit && (result.cause == CAUSE_TIMEOUT),
        (result.port_direction == 8'hFF) && !result.button_level && (item.operation == OP_TICK),
        "timeout result with wrong pattern")
    `CRC7FCR_ASSERT_NOW(a_tick_quiet, step_en && (item.operation == OP_TICK) &&
        (timeout_count_reg > 16'd1), !hit, "timeout fired with count left")
    `CRC7FCR_ASSERT_NEXT(a_reload, step_en && hit && (result.cause == CAUSE_PACKET),
        timeout_count_reg == $past(timeout_ticks), "valid packet did not reload timeout")

endmodule

>>> sv/crc7_framed_command_receiver.sv
// ----------------------------------------------------------------------------
// CRC7 framed command receiver
// Frames CRC-checked command packets and runs the millisecond output timeout.
// ----------------------------------------------------------------------------
// Accepts one request (a received byte or a tick) every clock cycle while
// cmd_stall is low. A request is captured in an input register, processed by
// the framing core once the result register can take it and, if it produces a
// result, lands in the result register. The only feedback path is the framing
// and timeout state inside the core, updated once per request. cmd_stall rises
// only while a request sits in the input register and the result register is
// full and stalled. The timeout_ticks register is written through
// cfg_we/cfg_data and takes effect on the next valid packet.
`include "crc7_framed_command_receiver_defines.svh"

module crc7_framed_command_receiver
    import crc7fcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_item_t   cmd,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res
);

    logic [15:0] timeout_ticks_reg;
    logic        stage_valid_reg, stage_valid_next;
    cmd_item_t   stage_item_reg;
    logic        res_valid_reg, res_valid_next;
    res_item_t   res_item_reg;

    logic        cmd_take;
    logic        advance;
    logic        step_en;
    logic        hit;
    res_item_t   result;

    // Hold the timeout reload value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_ticks_reg <= cfg_data;
        end
    end

    // Handshake control
    assign advance   = !res_valid_reg || !res_stall;
    assign step_en   = stage_valid_reg && advance;
    assign cmd_stall = stage_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign stage_valid_next = cmd_take || (stage_valid_reg && !advance);
    assign res_valid_next   = (step_en && hit) || (res_valid_reg && res_stall);

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            stage_item_reg <= cmd;
        end
    end

    crc7fcr_frame u_frame
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .item          (stage_item_reg),
        .timeout_ticks (timeout_ticks_reg),
        .hit           (hit),
        .result        (result)
    );

    // Register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && hit)
        begin
            res_item_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_item_reg;

    `CRC7FCR_ASSERT_NOW(a_stall_has_request, cmd_stall, stage_valid_reg && res_valid_reg,
        "stall without a held request")
    `CRC7FCR_ASSERT_NEXT(a_stage_hold, stage_valid_reg && !advance,
        stage_valid_reg && $stable(stage_item_reg), "held request lost or changed")
    `CRC7FCR_ASSERT_NEXT(a_take_loads, cmd_take, stage_valid_reg && (stage_item_reg == $past(cmd)),
        "accepted request not captured")

endmodule

>>> dv/crc7_framed_command_checker.sv
// ----------------------------------------------------------------------------
// CRC7 framed command receiver checker
// Watches the register, request and result ports. Keeps its own copy of the
// framing and timeout state, predicts every result and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module crc7_framed_command_checker
    import crc7fcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  cmd_item_t   cmd,
    input  logic        res_valid,
    input  logic        res_stall,
    input  res_item_t   res,
    output int          errors,
    output int          pending
);

    logic [15:0] reload_ticks = TIMEOUT_RESET;
    logic        framing      = 1'b0;
    logic [1:0]  frame_pos    = '0;
    logic [13:0] frame_word   = '0;
    logic [7:0]  frame_check  = '0;
    logic [15:0] ticks_left   = TIMEOUT_RESET;
    int          mismatches   = 0;
    res_item_t   due_outputs[$];

    // OR the byte into the check value, then shift through the polynomial
    function automatic logic [7:0] fold_check(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] v;
        v = acc | data;
        repeat (8)
        begin
            if (v[7])
            begin
                v = v ^ CHECK_POLY;
            end
            v = v << 1;
        end
        return v;
    endfunction

    // Apply the error masks and turn the word into the output lines
    function automatic res_item_t line_state(input logic [13:0] word, input cause_t why);
        logic [13:0] w;
        res_item_t   r;
        w = word;
        if ((w & ERR_HIGH_BIT) != '0)
        begin
            w = w & ERR_HIGH_KEEP;
        end
        if ((w & ERR_LOW_BIT) != '0)
        begin
            w = w & ERR_LOW_KEEP;
        end
        r.port_direction = ~w[8:1];
        r.button_level   = w[0];
        r.cause          = why;
        return r;
    endfunction

    // Advance the framing and timeout state by one request
    task automatic apply_request(input cmd_item_t req);
        if (req.operation == OP_TICK)
        begin
            if (ticks_left != '0)
            begin
                ticks_left = ticks_left - 16'd1;
            end
            if (ticks_left == '0)
            begin
                due_outputs.push_back(line_state('0, CAUSE_TIMEOUT));
            end
        end
        else if (req.rx_byte == START_BYTE)
        begin
            framing     = 1'b1;
            frame_pos   = 2'd0;
            frame_word  = '0;
            frame_check = fold_check('0, req.rx_byte);
        end
        else if (framing && !req.rx_byte[7] && frame_pos != 2'd3)
        begin
            case (frame_pos)
                2'd0:
                begin
                    frame_word  = {req.rx_byte[6:0], 7'd0};
                    frame_check = fold_check(frame_check, req.rx_byte);
                    frame_pos   = 2'd1;
                end
                2'd1:
                begin
                    frame_word  = frame_word | {7'd0, req.rx_byte[6:0] & DATA_MASK};
                    frame_check = fold_check(frame_check, req.rx_byte);
                    frame_pos   = 2'd2;
                end
                default:
                begin
                    frame_pos = 2'd3;
                    framing   = 1'b0;
                    if (req.rx_byte == {1'b0, frame_check[7:1]})
                    begin
                        due_outputs.push_back(line_state(frame_word, CAUSE_PACKET));
                        ticks_left = reload_ticks;
                    end
                end
            endcase
        end
        else
        begin
            framing = 1'b0;
        end
    endtask

    // Track register writes, predict on each request, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            reload_ticks = TIMEOUT_RESET;
            framing      = 1'b0;
            frame_pos    = '0;
            frame_word   = '0;
            frame_check  = '0;
            ticks_left   = TIMEOUT_RESET;
            mismatches   = 0;
            due_outputs.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                reload_ticks = cfg_data;
            end
            if (cmd_valid && !cmd_stall)
            begin
                apply_request(cmd);
            end
            if (res_valid && !res_stall)
            begin
                if (due_outputs.size() == 0)
                begin
                    $error("unexpected result: port_direction %h button_level %b cause %b",
                           res.port_direction, res.button_level, res.cause);
                    mismatches++;
                end
                else
                begin
                    want = due_outputs.pop_front();
                    if (res.port_direction !== want.port_direction)
                    begin
                        $error("port_direction mismatch: expected %h, actual %h",
                               want.port_direction, res.port_direction);
                        mismatches++;
                    end
                    if (res.button_level !== want.button_level)
                    begin
                        $error("button_level mismatch: expected %b, actual %b",
                               want.button_level, res.button_level);
                        mismatches++;
                    end
                    if (res.cause !== want.cause)
                    begin
                        $error("cause mismatch: expected %b, actual %b", want.cause, res.cause);
                        mismatches++;
                    end
                end
            end
        end
        errors  <= mismatches;
        pending <= due_outputs.size();
    end

endmodule

>>> dv/crc7_framed_command_receiver_tb.sv
// ----------------------------------------------------------------------------
// CRC7 framed command receiver testbench
// Drives framed command packets, broken packets, stray bytes and ticks under
// random idling on both channels and across several timeout settings; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module crc7_framed_command_receiver_tb;
    import crc7fcr_pkg::*;

    localparam int ITEM_TARGET   = 1300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;

    typedef enum int
    {
        PKT_GOOD,
        PKT_BAD_CHECK,
        PKT_HIGH_CHECK,
        PKT_ABORT,
        PKT_RESTART
    } pkt_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_item_t   cmd;
    logic        res_valid;
    logic        res_stall;
    res_item_t   res;

    logic        hold_req    = 1'b0;
    bit          gap_free    = 1'b0;
    int          sent        = 0;
    int          cycle_count = 0;
    int          errors;
    int          pending;

    crc7_framed_command_receiver dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    crc7_framed_command_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stall spans, plus one long hold-off on request
    initial
    begin
        int span;
        bit served;
        bit level;
        span   = 0;
        served = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !served)
            begin
                served = 1'b1;
                span   = HOLD_CYCLES;
                res_stall <= 1'b1;
            end
            else if (span > 1)
            begin
                span--;
            end
            else
            begin
                level = ($urandom_range(0, 99) < 30);
                if (level)
                begin
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(1, 3);
                end
                else
                begin
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
                end
                res_stall <= level;
            end
        end
    end

    // Idle gap before a request: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_free || roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_req(input op_t op, input logic [7:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{operation: op, rx_byte: value};
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    // Frame a 14-bit word, optionally broken in one of several ways
    task automatic send_packet(input logic [13:0] word, input pkt_kind_t kind);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] crc_sum;
        logic [7:0] tail;
        hi      = {1'b0, word[13:7]};
        lo      = {1'b0, word[6:0]};
        crc_sum = check_step(check_step(check_step('0, START_BYTE), hi), lo);
        tail    = {1'b0, crc_sum[7:1]};
        case (kind)
            PKT_BAD_CHECK:  tail = tail ^ {1'b0, 7'($urandom_range(1, 127))};
            PKT_HIGH_CHECK: tail = 8'($urandom_range(129, 255));
            default:        ;
        endcase
        if (kind == PKT_RESTART)
        begin
            send_req(OP_BYTE, START_BYTE);
            send_req(OP_BYTE, 8'($urandom_range(0, 127)));
        end
        send_req(OP_BYTE, START_BYTE);
        send_req(OP_BYTE, hi);
        if (kind == PKT_ABORT)
        begin
            send_req(OP_BYTE, 8'($urandom_range(129, 255)));
        end
        send_req(OP_BYTE, lo);
        send_req(OP_BYTE, tail);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Random mix: mostly well-formed packets, then broken ones, noise and ticks
    task automatic run_traffic(input int quota);
        int stop_at;
        int roll;
        stop_at = sent + quota;
        while (sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                send_packet(14'($urandom()), PKT_GOOD);
            end
            else if (roll < 63)
            begin
                send_packet(14'($urandom()), PKT_BAD_CHECK);
            end
            else if (roll < 67)
            begin
                send_packet(14'($urandom()), PKT_HIGH_CHECK);
            end
            else if (roll < 71)
            begin
                send_packet(14'($urandom()), PKT_ABORT);
            end
            else if (roll < 75)
            begin
                send_packet(14'($urandom()), PKT_RESTART);
            end
            else if (roll < 85)
            begin
                send_req(OP_BYTE, 8'($urandom()));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_req(OP_TICK, 8'($urandom()));
            end
        end
    endtask

    initial
    begin
        logic [15:0] phase_ticks [0:5];
        int          phase;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        phase_ticks = '{16'd65535, 16'd3, 16'd0, 16'd1, 16'd250,
                        16'($urandom_range(2, 65534))};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick, stray byte, word extremes, error masks, broken packets
        send_req(OP_TICK, 8'hFF);
        send_req(OP_BYTE, 8'hFF);
        send_packet(14'h0000, PKT_GOOD);
        send_packet(14'h3FFF, PKT_GOOD);
        send_packet(14'h1FFF, PKT_RESTART);
        send_packet(14'h2AAA, PKT_ABORT);
        send_packet(14'h0FFF, PKT_BAD_CHECK);
        send_packet(14'h0AAA, PKT_HIGH_CHECK);

        // Zero reload: each tick emits the off pattern, bytes never do
        drain();
        write_timeout(16'd0);
        send_packet(14'h1234, PKT_GOOD);
        send_req(OP_TICK, 8'h00);
        send_req(OP_TICK, 8'h00);
        send_req(OP_BYTE, 8'h00);

        // Long receiver hold-off while ticks keep producing results
        drain();
        write_timeout(16'd1);
        hold_req <= 1'b1;
        gap_free = 1'b1;
        send_packet(14'h0321, PKT_GOOD);
        repeat (40) send_req(OP_TICK, 8'($urandom()));
        gap_free = 1'b0;

        // Random phases, one timeout setting each
        for (phase = 0; phase < 6; phase++)
        begin
            drain();
            write_timeout(phase_ticks[phase]);
            gap_free = (phase == 2);
            run_traffic((ITEM_TARGET - sent) / (6 - phase));
        end

        drain();
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
